>>> src/nrq_pkg.sv
package nrq_pkg;

   localparam int SEQ_W     = 32;
   localparam int RETRY_W   = 4;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int VISITED_W = 6;
   localparam int TOTAL_W   = 32;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_PROCESS = 1'b1;

   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESEND  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_QUEUED    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd2;

   localparam logic [RETRY_W-1:0] RETRIES_RESET = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REQ_RD,
      ST_REQ_EV,
      ST_REQ_DONE,
      ST_PASS_RD,
      ST_PASS_EV,
      ST_PASS_DONE
   } state_type;

endpackage

>>> src/nrq_req_if.sv
interface nrq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [nrq_pkg::SEQ_W-1:0]     sequence_req;

   modport source (output valid, output opcode, output sequence_req, input ready);
   modport sink (input valid, input opcode, input sequence_req, output ready);
endinterface

>>> src/nrq_rsp_if.sv
interface nrq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [nrq_pkg::KIND_W-1:0]      kind;
   logic [nrq_pkg::STATUS_W-1:0]    status;
   logic [nrq_pkg::SEQ_W-1:0]       resend_sequence;
   logic [nrq_pkg::RETRY_W-1:0]     attempt;
   logic [nrq_pkg::VISITED_W-1:0]   visited_count;
   logic [nrq_pkg::TOTAL_W-1:0]     resend_total;
   logic                            last;

   modport source (output valid, output kind, output status, output resend_sequence,
                   output attempt, output visited_count, output resend_total,
                   output last, input ready);
   modport sink (input valid, input kind, input status, input resend_sequence,
                 input attempt, input visited_count, input resend_total,
                 input last, output ready);
endinterface

>>> src/nack_retransmit_queue_unit.sv
// Ordered queue of lost sequence numbers with per-entry retry counts. A request word
// scans the queue one entry at a time (memory read, then compare) and answers with
// one status word: duplicate, queued or dropped when full. A process word walks every
// entry the same way, writing kept entries back toward the head of the queue with their
// count raised and emitting a resend word for each, dropping entries at or above the
// limit, and ends with a summary word. The queue memory has a registered read and there
// is one compare unit, so each entry is read in one state and compared in the next; a
// stalled result port holds the walk until it takes the word.
// The block takes a new word only when the previous one is fully processed.
module nack_retransmit_queue_unit #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   nrq_req_if.sink                     req_chan,
   nrq_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [nrq_pkg::RETRY_W-1:0] csr_wdata
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   // queue memory
   logic [nrq_pkg::SEQ_W-1:0]   seq_mem [QUEUE_DEPTH];
   logic [nrq_pkg::RETRY_W-1:0] retry_mem [QUEUE_DEPTH];
   logic [nrq_pkg::SEQ_W-1:0]   rd_seq_ff;
   logic [nrq_pkg::RETRY_W-1:0] rd_retry_ff;

   nrq_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   wr_ff, wr_in;
   logic [CNT_W-1:0]   visited_ff, visited_in;
   logic [nrq_pkg::SEQ_W-1:0]   seq_ff, seq_in;
   logic [nrq_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [nrq_pkg::RETRY_W-1:0] max_retries_ff;

   logic                        rd_en;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_waddr;
   logic [nrq_pkg::SEQ_W-1:0]   mem_wseq;
   logic [nrq_pkg::RETRY_W-1:0] mem_wretry;
   logic [nrq_pkg::RETRY_W-1:0] bumped;

   // output register
   logic                          out_free;
   logic                          emit;
   logic [nrq_pkg::KIND_W-1:0]    e_kind;
   logic [nrq_pkg::STATUS_W-1:0]  e_status;
   logic [nrq_pkg::SEQ_W-1:0]     e_seq;
   logic [nrq_pkg::RETRY_W-1:0]   e_attempt;
   logic [nrq_pkg::VISITED_W-1:0] e_visited;
   logic                          e_last;

   logic                            rsp_valid_ff;
   logic [nrq_pkg::KIND_W-1:0]      rsp_kind_ff;
   logic [nrq_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [nrq_pkg::SEQ_W-1:0]       rsp_seq_ff;
   logic [nrq_pkg::RETRY_W-1:0]     rsp_attempt_ff;
   logic [nrq_pkg::VISITED_W-1:0]   rsp_visited_ff;
   logic [nrq_pkg::TOTAL_W-1:0]     rsp_total_ff;
   logic                            rsp_last_ff;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == nrq_pkg::ST_IDLE);
   assign bumped         = rd_retry_ff + 1'b1;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      wr_in      = wr_ff;
      visited_in = visited_ff;
      seq_in     = seq_ff;
      total_in   = total_ff;
      rd_en      = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = wr_ff[IDX_W-1:0];
      mem_wseq   = rd_seq_ff;
      mem_wretry = bumped;
      emit       = 1'b0;
      e_kind     = nrq_pkg::KIND_STATUS;
      e_status   = nrq_pkg::STATUS_QUEUED;
      e_seq      = '0;
      e_attempt  = '0;
      e_visited  = '0;
      e_last     = 1'b0;
      case (state_ff)
         nrq_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               seq_in     = req_chan.sequence_req;
               idx_in     = '0;
               wr_in      = '0;
               visited_in = count_ff;
               if (req_chan.opcode == nrq_pkg::OP_REQUEST) begin
                  state_in = (count_ff == '0) ? nrq_pkg::ST_REQ_DONE : nrq_pkg::ST_REQ_RD;
               end else begin
                  state_in = (count_ff == '0) ? nrq_pkg::ST_PASS_DONE : nrq_pkg::ST_PASS_RD;
               end
            end
         end
         nrq_pkg::ST_REQ_RD: begin
            rd_en    = 1'b1;
            state_in = nrq_pkg::ST_REQ_EV;
         end
         nrq_pkg::ST_REQ_EV: begin
            if (rd_seq_ff == seq_ff) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_status = nrq_pkg::STATUS_DUPLICATE;
                  e_seq    = seq_ff;
                  e_last   = 1'b1;
                  state_in = nrq_pkg::ST_IDLE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == count_ff) ? nrq_pkg::ST_REQ_DONE
                                                      : nrq_pkg::ST_REQ_RD;
            end
         end
         nrq_pkg::ST_REQ_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_seq    = seq_ff;
               e_last   = 1'b1;
               state_in = nrq_pkg::ST_IDLE;
               if (count_ff < DEPTH_CNT) begin
                  mem_we     = 1'b1;
                  mem_waddr  = count_ff[IDX_W-1:0];
                  mem_wseq   = seq_ff;
                  mem_wretry = '0;
                  count_in   = count_ff + 1'b1;
                  e_status   = nrq_pkg::STATUS_QUEUED;
               end else begin
                  e_status   = nrq_pkg::STATUS_DROPPED;
               end
            end
         end
         nrq_pkg::ST_PASS_RD: begin
            rd_en    = 1'b1;
            state_in = nrq_pkg::ST_PASS_EV;
         end
         nrq_pkg::ST_PASS_EV: begin
            if (rd_retry_ff < max_retries_ff) begin
               if (out_free) begin
                  // kept entry closes up to the write index
                  mem_we    = 1'b1;
                  wr_in     = wr_ff + 1'b1;
                  total_in  = total_ff + 1'b1;
                  emit      = 1'b1;
                  e_kind    = nrq_pkg::KIND_RESEND;
                  e_seq     = rd_seq_ff;
                  e_attempt = bumped;
                  idx_in    = idx_ff + 1'b1;
                  state_in  = (idx_ff + 1'b1 == visited_ff) ? nrq_pkg::ST_PASS_DONE
                                                            : nrq_pkg::ST_PASS_RD;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == visited_ff) ? nrq_pkg::ST_PASS_DONE
                                                        : nrq_pkg::ST_PASS_RD;
            end
         end
         nrq_pkg::ST_PASS_DONE: begin
            if (out_free) begin
               count_in  = wr_ff;
               emit      = 1'b1;
               e_kind    = nrq_pkg::KIND_SUMMARY;
               e_visited = nrq_pkg::VISITED_W'(visited_ff);
               e_last    = 1'b1;
               state_in  = nrq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nrq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= nrq_pkg::ST_IDLE;
         count_ff       <= '0;
         idx_ff         <= '0;
         wr_ff          <= '0;
         visited_ff     <= '0;
         total_ff       <= '0;
         max_retries_ff <= nrq_pkg::RETRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         wr_ff      <= wr_in;
         visited_ff <= visited_in;
         total_ff   <= total_in;
         if (csr_we) begin
            max_retries_ff <= csr_wdata;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      if (emit) begin
         rsp_kind_ff    <= e_kind;
         rsp_status_ff  <= e_status;
         rsp_seq_ff     <= e_seq;
         rsp_attempt_ff <= e_attempt;
         rsp_visited_ff <= e_visited;
         rsp_total_ff   <= total_in;
         rsp_last_ff    <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seq_mem[mem_waddr]   <= mem_wseq;
         retry_mem[mem_waddr] <= mem_wretry;
      end
      if (rd_en) begin
         rd_seq_ff   <= seq_mem[idx_ff[IDX_W-1:0]];
         rd_retry_ff <= retry_mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.kind            = rsp_kind_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.resend_sequence = rsp_seq_ff;
   assign rsp_chan.attempt         = rsp_attempt_ff;
   assign rsp_chan.visited_count   = rsp_visited_ff;
   assign rsp_chan.resend_total    = rsp_total_ff;
   assign rsp_chan.last            = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count above depth");

   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nrq_pkg::ST_PASS_EV) |-> (wr_ff <= idx_ff && idx_ff < visited_ff))
      else $error("pass write index ahead of read index");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (total_ff == $past(total_ff)) || (total_ff == $past(total_ff) + 1'b1))
      else $error("resend total moved by more than one");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwritten before taken");

endmodule
